// ===== rtl/srt_pkg.sv =====
// Shared types, character codes and character-class helpers for the syntax rule tokenizer.
// No dependencies.
package srt_pkg;

	typedef enum logic [3:0] {
		K_CONTENT = 4'd0,
		K_EOF     = 4'd1,
		K_ERROR   = 4'd2,
		K_OCTET   = 4'd3,
		K_STRING  = 4'd4,
		K_OFFSET  = 4'd5,
		K_OFFREF  = 4'd6,
		K_COLOUR  = 4'd7,
		K_OPEN    = 4'd8,
		K_CLOSE   = 4'd9,
		K_TERM    = 4'd10
	} kind_t;

	typedef enum logic [2:0] {
		M_IDLE    = 3'd0,
		M_COMMENT = 3'd1,
		M_STRING  = 3'd2,
		M_OFFSET  = 3'd3,
		M_OFFREF  = 3'd4,
		M_WORD    = 3'd5
	} mode_t;

	localparam int LEN_W = 13;

	typedef struct packed {
		kind_t              kind;
		logic [7:0]         ch;
		logic [LEN_W-1:0]   len;
		logic               last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    r0;
		result_t    r1;
	} step_t;

	localparam logic [7:0] CH_NL    = 8'h0A;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_QUOTE = 8'h22;
	localparam logic [7:0] CH_HASH  = 8'h23;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_AMP   = 8'h26;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_OPEN  = 8'h7B;
	localparam logic [7:0] CH_CLOSE = 8'h7D;
	localparam logic [7:0] CH_SEMI  = 8'h3B;

	function automatic logic is_space(input logic [7:0] c);
		return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_hex(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A)
			|| (c == CH_SLASH);
	endfunction

	function automatic result_t mk_result(input kind_t k, input logic [7:0] ch,
			input logic [LEN_W-1:0] len);
		result_t r;
		r.kind = k;
		r.ch   = ch;
		r.len  = len;
		r.last = 1'b0;
		return r;
	endfunction

endpackage

// ===== rtl/srt_scan.sv =====
// Scanner step: results and next scan state for one byte or end marker.
// Depends on srt_pkg.
module srt_scan #(
	parameter int MAX_TOKEN = 8191,
	parameter int CW = 13
) (
	input  logic [7:0]      text_byte,
	input  logic            end_of_text,
	input  srt_pkg::mode_t  mode,
	input  logic            colour,
	input  logic [CW-1:0]   count,
	output srt_pkg::step_t  step,
	output srt_pkg::mode_t  mode_nx,
	output logic            colour_nx,
	output logic [CW-1:0]   count_nx
);

	typedef struct packed {
		logic             has;
		srt_pkg::result_t r;
		srt_pkg::mode_t   mode;
		logic             colour;
		logic             cnt_one;
	} ib_t;

	localparam logic [CW:0] MAX_W = (CW+1)'(MAX_TOKEN);
	localparam logic FIRST_FAILS = (MAX_TOKEN <= 1);

	logic [7:0]                  c;
	logic                        tk_err;
	srt_pkg::result_t            tk_res;
	logic [CW:0]                 tk_sum;
	srt_pkg::result_t            close_r;
	logic [srt_pkg::LEN_W-1:0]   len;
	ib_t                         ib;
	logic [CW-1:0]               ib_cnt;

	assign c      = text_byte;
	assign len    = srt_pkg::LEN_W'(count);
	assign tk_sum = {1'b0, count} + (CW+1)'(1);
	assign tk_err = tk_sum >= MAX_W;
	assign tk_res = tk_err ? srt_pkg::mk_result(srt_pkg::K_ERROR, 8'h00, '0)
		: srt_pkg::mk_result(srt_pkg::K_CONTENT, c, '0);
	assign ib_cnt = ib.cnt_one ? CW'(1) : '0;

	always_comb begin
		case (mode)
			srt_pkg::M_OFFSET: begin
				close_r = (count == '0) ? srt_pkg::mk_result(srt_pkg::K_ERROR, 8'h00, '0)
					: srt_pkg::mk_result(srt_pkg::K_OFFSET, 8'h00, len);
			end
			srt_pkg::M_OFFREF: begin
				close_r = (count == '0) ? srt_pkg::mk_result(srt_pkg::K_ERROR, 8'h00, '0)
					: srt_pkg::mk_result(srt_pkg::K_OFFREF, 8'h00, len);
			end
			default: begin
				close_r = srt_pkg::mk_result(colour ? srt_pkg::K_COLOUR : srt_pkg::K_OCTET,
					8'h00, len);
			end
		endcase
	end

	always_comb begin
		ib.has     = 1'b0;
		ib.r       = srt_pkg::mk_result(srt_pkg::K_ERROR, 8'h00, '0);
		ib.mode    = srt_pkg::M_IDLE;
		ib.colour  = 1'b0;
		ib.cnt_one = 1'b0;
		if (srt_pkg::is_space(c)) begin
			ib.has = 1'b0;
		end else if (c == srt_pkg::CH_HASH) begin
			ib.mode = srt_pkg::M_COMMENT;
		end else if (c == srt_pkg::CH_QUOTE) begin
			ib.mode = srt_pkg::M_STRING;
		end else if (c == srt_pkg::CH_PLUS) begin
			ib.mode = srt_pkg::M_OFFSET;
		end else if (c == srt_pkg::CH_AMP) begin
			ib.mode = srt_pkg::M_OFFREF;
		end else if (c == srt_pkg::CH_OPEN) begin
			ib.has = 1'b1;
			ib.r   = srt_pkg::mk_result(srt_pkg::K_OPEN, 8'h00, '0);
		end else if (c == srt_pkg::CH_CLOSE) begin
			ib.has = 1'b1;
			ib.r   = srt_pkg::mk_result(srt_pkg::K_CLOSE, 8'h00, '0);
		end else if (c == srt_pkg::CH_SEMI) begin
			ib.has = 1'b1;
			ib.r   = srt_pkg::mk_result(srt_pkg::K_TERM, 8'h00, '0);
		end else if (srt_pkg::is_word_char(c)) begin
			ib.has = 1'b1;
			if (!FIRST_FAILS) begin
				ib.r       = srt_pkg::mk_result(srt_pkg::K_CONTENT, c, '0);
				ib.mode    = srt_pkg::M_WORD;
				ib.colour  = !srt_pkg::is_hex(c);
				ib.cnt_one = 1'b1;
			end
		end else begin
			ib.has = 1'b1;
		end
	end

	always_comb begin
		step.n    = 2'd0;
		step.r0   = srt_pkg::mk_result(srt_pkg::K_EOF, 8'h00, '0);
		step.r1   = srt_pkg::mk_result(srt_pkg::K_EOF, 8'h00, '0);
		mode_nx   = mode;
		colour_nx = colour;
		count_nx  = count;
		if (end_of_text) begin
			mode_nx   = srt_pkg::M_IDLE;
			colour_nx = 1'b0;
			count_nx  = '0;
			if (mode == srt_pkg::M_STRING) begin
				step.n  = 2'd2;
				step.r0 = srt_pkg::mk_result(srt_pkg::K_ERROR, 8'h00, '0);
			end else if (mode == srt_pkg::M_OFFSET || mode == srt_pkg::M_OFFREF
					|| mode == srt_pkg::M_WORD) begin
				step.n  = 2'd2;
				step.r0 = close_r;
			end else begin
				step.n  = 2'd1;
			end
		end else begin
			case (mode)
				srt_pkg::M_COMMENT: begin
					if (c == srt_pkg::CH_NL) begin
						mode_nx   = srt_pkg::M_IDLE;
						colour_nx = 1'b0;
						count_nx  = '0;
					end
				end
				srt_pkg::M_STRING: begin
					step.n = 2'd1;
					if (c == srt_pkg::CH_QUOTE) begin
						step.r0   = srt_pkg::mk_result(srt_pkg::K_STRING, 8'h00, len);
						mode_nx   = srt_pkg::M_IDLE;
						colour_nx = 1'b0;
						count_nx  = '0;
					end else begin
						step.r0 = tk_res;
						if (tk_err) begin
							mode_nx   = srt_pkg::M_IDLE;
							colour_nx = 1'b0;
							count_nx  = '0;
						end else begin
							count_nx = tk_sum[CW-1:0];
						end
					end
				end
				srt_pkg::M_OFFSET, srt_pkg::M_OFFREF, srt_pkg::M_WORD: begin
					if ((mode == srt_pkg::M_WORD) ? srt_pkg::is_word_char(c)
							: srt_pkg::is_digit(c)) begin
						step.n  = 2'd1;
						step.r0 = tk_res;
						if (tk_err) begin
							mode_nx   = srt_pkg::M_IDLE;
							colour_nx = 1'b0;
							count_nx  = '0;
						end else begin
							count_nx  = tk_sum[CW-1:0];
							colour_nx = colour
								| ((mode == srt_pkg::M_WORD) && !srt_pkg::is_hex(c));
						end
					end else begin
						step.n    = ib.has ? 2'd2 : 2'd1;
						step.r0   = close_r;
						step.r1   = ib.r;
						mode_nx   = ib.mode;
						colour_nx = ib.colour;
						count_nx  = ib_cnt;
					end
				end
				default: begin
					step.n    = ib.has ? 2'd1 : 2'd0;
					step.r0   = ib.r;
					mode_nx   = ib.mode;
					colour_nx = ib.colour;
					count_nx  = ib_cnt;
				end
			endcase
		end
		if (step.n == 2'd1) begin
			step.r0.last = 1'b1;
		end
		if (step.n == 2'd2) begin
			step.r1.last = 1'b1;
		end
	end

endmodule

// ===== rtl/syntax_rule_tokenizer.sv =====
// Top level of the syntax rule tokenizer: input register, scan state and result queue.
// Depends on srt_pkg and srt_scan.
//
// Takes one byte (or end marker) per cycle and returns tokens as content results followed by
// a token-end result. An item is registered, scanned combinationally and its zero, one or two
// results are written to a four-entry result queue, which registers them before they can
// leave. Input is taken every cycle while the queue holds at most two
// results, so the sustained rate is one item per cycle as long as results drain at one per
// cycle on average; bytes that yield two results are absorbed by the queue and only stall
// input when such bytes follow one another faster than the output port drains them.
module syntax_rule_tokenizer #(
	parameter int MAX_TOKEN = 8191
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  text_byte,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  kind,
	output logic [7:0]  char_value,
	output logic [12:0] token_length,
	output logic        last_of_run
);

	localparam int CW = $clog2(MAX_TOKEN + 1);

	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 eot_s1;
	logic                 advance;

	srt_pkg::mode_t       mode_q;
	logic                 colour_q;
	logic [CW-1:0]        count_q;
	srt_pkg::mode_t       mode_nx;
	logic                 colour_nx;
	logic [CW-1:0]        count_nx;
	srt_pkg::step_t       step;

	srt_pkg::result_t     fifo_q [4];
	logic [1:0]           wp_q;
	logic [1:0]           rp_q;
	logic [2:0]           cnt_q;
	logic                 pop;
	logic [1:0]           push_n;
	srt_pkg::result_t     head;

	assign advance  = valid_s1 && (cnt_q <= 3'd2);
	assign in_stall = valid_s1 && !advance;
	assign push_n   = advance ? step.n : 2'd0;
	assign pop      = out_valid && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall) begin
			byte_s1 <= text_byte;
			eot_s1  <= end_of_text;
		end
	end

	srt_scan #(
		.MAX_TOKEN(MAX_TOKEN),
		.CW(CW)
	) u_scan (
		.text_byte(byte_s1),
		.end_of_text(eot_s1),
		.mode(mode_q),
		.colour(colour_q),
		.count(count_q),
		.step(step),
		.mode_nx(mode_nx),
		.colour_nx(colour_nx),
		.count_nx(count_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= srt_pkg::M_IDLE;
			colour_q <= 1'b0;
			count_q  <= '0;
		end else if (advance) begin
			mode_q   <= mode_nx;
			colour_q <= colour_nx;
			count_q  <= count_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			fifo_q[wp_q] <= step.r0;
		end
		if (push_n == 2'd2) begin
			fifo_q[wp_q + 2'd1] <= step.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			wp_q  <= wp_q + push_n;
			rp_q  <= rp_q + {1'b0, pop};
			cnt_q <= cnt_q + {1'b0, push_n} - {2'b00, pop};
		end
	end

	assign head         = fifo_q[rp_q];
	assign out_valid    = (cnt_q != 3'd0);
	assign kind         = head.kind;
	assign char_value   = head.ch;
	assign token_length = head.len;
	assign last_of_run  = head.last;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("result queue overflow");

	a_no_stall_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !in_stall)
		else $error("stall with empty input register");

	a_eot_idle: assert property (@(posedge clk) disable iff (!arst_n)
		advance && eot_s1 |=> mode_q == srt_pkg::M_IDLE && count_q == '0)
		else $error("scan state not cleared after end of text");

	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push_n == 2'd2 |-> !step.r0.last && step.r1.last)
		else $error("last flag misplaced in result pair");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for syntax_rule_tokenizer: streams text bytes through the block and
// checks every token result against an in-line tokenizer model. Depends on srt_pkg and the RTL.
module tb;

	localparam int MAX_LEN = 8191;
	localparam int ITEMS = 1200;
	localparam int LIMIT = 10000000;

	typedef struct packed {
		logic [7:0] b;
		logic       eot;
	} text_item_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  text_byte = 8'h00;
	logic        end_of_text = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [3:0]  kind;
	logic [7:0]  char_value;
	logic [12:0] token_length;
	logic        last_of_run;
	logic        hold_off = 1'b0;

	text_item_t        text_q[$];
	srt_pkg::result_t  tokens_due[$];
	srt_pkg::result_t  step_out[$];
	srt_pkg::mode_t    scan_state;
	bit                colour_word;
	int unsigned       taken;
	int unsigned       fed = 0;
	int unsigned       seen = 0;
	int unsigned       mismatches = 0;
	int unsigned       cycles = 0;
	int                send_gap = 0;
	int                drain_gap = 0;

	syntax_rule_tokenizer #(.MAX_TOKEN(MAX_LEN)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.text_byte(text_byte),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.char_value(char_value),
		.token_length(token_length),
		.last_of_run(last_of_run)
	);

	function automatic bit blank(logic [7:0] c);
		return c == srt_pkg::CH_SPACE || (c >= srt_pkg::CH_TAB && c <= srt_pkg::CH_CR);
	endfunction

	function automatic bit decimal(logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic bit hex_char(logic [7:0] c);
		return decimal(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
	endfunction

	function automatic bit word_char(logic [7:0] c);
		return decimal(c) || (c >= "a" && c <= "z") || (c >= "A" && c <= "Z")
			|| c == srt_pkg::CH_SLASH;
	endfunction

	function automatic void post_token(srt_pkg::kind_t k, logic [7:0] c, int unsigned n);
		srt_pkg::result_t r;
		r.kind = k;
		r.ch = c;
		r.len = n[srt_pkg::LEN_W-1:0];
		r.last = 1'b0;
		step_out.push_back(r);
	endfunction

	function automatic void clear_scan();
		scan_state = srt_pkg::M_IDLE;
		colour_word = 1'b0;
		taken = 0;
	endfunction

	function automatic void take_char(logic [7:0] c);
		if (taken + 1 >= MAX_LEN) begin
			post_token(srt_pkg::K_ERROR, 8'h00, 0);
			clear_scan();
		end else begin
			post_token(srt_pkg::K_CONTENT, c, 0);
			taken++;
		end
	endfunction

	function automatic void open_token(logic [7:0] c);
		if (blank(c)) begin
		end else if (c == srt_pkg::CH_HASH) begin
			scan_state = srt_pkg::M_COMMENT;
		end else if (c == srt_pkg::CH_QUOTE) begin
			scan_state = srt_pkg::M_STRING;
			taken = 0;
		end else if (c == srt_pkg::CH_PLUS) begin
			scan_state = srt_pkg::M_OFFSET;
			taken = 0;
		end else if (c == srt_pkg::CH_AMP) begin
			scan_state = srt_pkg::M_OFFREF;
			taken = 0;
		end else if (c == srt_pkg::CH_OPEN) begin
			post_token(srt_pkg::K_OPEN, 8'h00, 0);
		end else if (c == srt_pkg::CH_CLOSE) begin
			post_token(srt_pkg::K_CLOSE, 8'h00, 0);
		end else if (c == srt_pkg::CH_SEMI) begin
			post_token(srt_pkg::K_TERM, 8'h00, 0);
		end else if (word_char(c)) begin
			scan_state = srt_pkg::M_WORD;
			taken = 0;
			colour_word = !hex_char(c);
			take_char(c);
		end else begin
			post_token(srt_pkg::K_ERROR, 8'h00, 0);
		end
	endfunction

	function automatic void close_token();
		if (scan_state == srt_pkg::M_OFFSET || scan_state == srt_pkg::M_OFFREF) begin
			if (taken == 0)
				post_token(srt_pkg::K_ERROR, 8'h00, 0);
			else if (scan_state == srt_pkg::M_OFFSET)
				post_token(srt_pkg::K_OFFSET, 8'h00, taken);
			else
				post_token(srt_pkg::K_OFFREF, 8'h00, taken);
			clear_scan();
		end else if (scan_state == srt_pkg::M_WORD) begin
			if (colour_word)
				post_token(srt_pkg::K_COLOUR, 8'h00, taken);
			else
				post_token(srt_pkg::K_OCTET, 8'h00, taken);
			clear_scan();
		end
	endfunction

	function automatic void scan_byte(logic [7:0] c, logic eot);
		step_out.delete();
		if (eot) begin
			if (scan_state == srt_pkg::M_STRING)
				post_token(srt_pkg::K_ERROR, 8'h00, 0);
			else
				close_token();
			post_token(srt_pkg::K_EOF, 8'h00, 0);
			clear_scan();
		end else begin
			case (scan_state)
				srt_pkg::M_COMMENT: begin
					if (c == srt_pkg::CH_NL)
						clear_scan();
				end
				srt_pkg::M_STRING: begin
					if (c == srt_pkg::CH_QUOTE) begin
						post_token(srt_pkg::K_STRING, 8'h00, taken);
						clear_scan();
					end else begin
						take_char(c);
					end
				end
				srt_pkg::M_OFFSET, srt_pkg::M_OFFREF: begin
					if (decimal(c)) begin
						take_char(c);
					end else begin
						close_token();
						open_token(c);
					end
				end
				srt_pkg::M_WORD: begin
					if (word_char(c)) begin
						if (!hex_char(c))
							colour_word = 1'b1;
						take_char(c);
					end else begin
						close_token();
						open_token(c);
					end
				end
				default: begin
					clear_scan();
					open_token(c);
				end
			endcase
		end
		if (step_out.size() > 0)
			step_out[step_out.size() - 1].last = 1'b1;
		foreach (step_out[i])
			tokens_due.push_back(step_out[i]);
	endfunction

	function automatic void queue_byte(logic [7:0] c);
		text_q.push_back(text_item_t'{b: c, eot: 1'b0});
	endfunction

	function automatic void queue_end();
		text_q.push_back(text_item_t'{b: 8'($urandom), eot: 1'b1});
	endfunction

	function automatic void queue_text(string s);
		foreach (s[i])
			queue_byte(s[i]);
	endfunction

	function automatic logic [7:0] pick_from(string s);
		return s[$urandom_range(0, s.len() - 1)];
	endfunction

	function automatic logic [7:0] non_quote();
		logic [7:0] c;
		c = 8'($urandom_range(0, 255));
		while (c == srt_pkg::CH_QUOTE)
			c = 8'($urandom_range(0, 255));
		return c;
	endfunction

	function automatic int run_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 6);
		return $urandom_range(7, 30);
	endfunction

	function automatic int pick_gap(bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	task automatic report_mismatch(string what, srt_pkg::result_t want);
		mismatches++;
		$display("%0t %s: got kind=%0d char=%02h len=%0d last=%0b, %s%0d %s%02h %s%0d %s%0b",
			$realtime, what, kind, char_value, token_length, last_of_run,
			"want kind=", want.kind, "char=", want.ch, "len=", want.len,
			"last=", want.last);
	endtask

	task automatic check_token();
		srt_pkg::result_t want;
		if (tokens_due.size() == 0) begin
			want = '0;
			report_mismatch("result with none pending", want);
		end else begin
			want = tokens_due.pop_front();
			if (kind !== want.kind || char_value !== want.ch || token_length !== want.len
					|| last_of_run !== want.last)
				report_mismatch("token mismatch", want);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
	end

	// sender: hold the payload while stalled, advance on transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				scan_byte(text_byte, end_of_text);
				void'(text_q.pop_front());
				fed++;
			end
			if (!in_valid || !in_stall) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (text_q.size() > 0) begin
					in_valid <= 1'b1;
					text_byte <= text_q[0].b;
					end_of_text <= text_q[0].eot;
					send_gap = pick_gap(((fed / 100) % 3) == 1);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				check_token();
				seen++;
			end
			if (drain_gap > 0)
				drain_gap--;
			else
				drain_gap = pick_gap(((seen / 100) % 3) == 1);
			out_stall <= hold_off || drain_gap > 0;
		end
	end

	// long receiver hold-off so the block backs up into its input
	initial begin
		while (fed < 60)
			@(posedge clk);
		hold_off <= 1'b1;
		repeat (400) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		while (cycles < LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		int n;
		int pick;
		int counted;
		bit hex_only;
		logic [7:0] c;
		string hex_set;
		string word_set;
		string blank_set;
		hex_set = "0123456789abcdefABCDEF";
		word_set = "0123456789abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ/";
		blank_set = " \t\n\r\v\f";
		clear_scan();

		queue_text("{};+9&x F/ #}\n");
		queue_byte(8'hFF);
		queue_byte(8'h00);
		queue_text("\"a");
		queue_end();
		queue_text("0");
		queue_end();
		queue_text("+");
		queue_end();
		queue_text("&5");
		queue_end();

		counted = 0;
		while (counted < ITEMS) begin
			pick = $urandom_range(0, 19);
			n = run_len();
			if (pick < 6) begin
				hex_only = $urandom_range(0, 1);
				repeat (n) queue_byte(pick_from(hex_only ? hex_set : word_set));
				counted += n;
			end else if (pick < 9) begin
				queue_byte($urandom_range(0, 1) ? srt_pkg::CH_PLUS : srt_pkg::CH_AMP);
				if ($urandom_range(0, 9) == 0)
					n = 0;
				repeat (n) queue_byte(pick_from("0123456789"));
				counted += n + 1;
			end else if (pick < 12) begin
				queue_byte(srt_pkg::CH_QUOTE);
				repeat (n) queue_byte(non_quote());
				if ($urandom_range(0, 9) == 0)
					queue_end();
				else
					queue_byte(srt_pkg::CH_QUOTE);
				counted += n + 2;
			end else if (pick < 14) begin
				queue_byte(pick_from("{};"));
				counted++;
			end else if (pick == 14) begin
				queue_byte(srt_pkg::CH_HASH);
				repeat (n) begin
					c = 8'($urandom_range(0, 255));
					if (c != srt_pkg::CH_NL)
						queue_byte(c);
				end
				queue_byte(srt_pkg::CH_NL);
				counted += n + 2;
			end else if (pick < 17) begin
				repeat (n) queue_byte(8'($urandom_range(0, 255)));
				counted += n;
			end else if (pick == 17) begin
				queue_end();
				counted++;
			end
			if ($urandom_range(0, 1)) begin
				queue_byte(pick_from(blank_set));
				counted++;
			end
		end
		queue_end();

		while (text_q.size() != 0 || tokens_due.size() != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && tokens_due.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/srt_pkg.sv
rtl/srt_scan.sv
rtl/syntax_rule_tokenizer.sv
tb/tb.sv
